FILE: rtl/core/tarc_pkg.sv
// Shared types and constants for the touch auto-repeat clock controller.
package tarc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int CNT_W      = 8;
    localparam int IDLE_W     = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SETTLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND     = 2'd3;

    localparam logic [CNT_W-1:0]  SETTLE_RST     = 8'd1;
    localparam logic [CNT_W-1:0]  AUTO_DELAY_RST = 8'd1;
    localparam logic [CNT_W-1:0]  REPEAT_RST     = 8'd1;
    localparam logic [IDLE_W-1:0] SECOND_RST     = 10'd19;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    typedef struct packed {
        logic [CNT_W-1:0]  settle_ticks;
        logic [CNT_W-1:0]  auto_delay_ticks;
        logic [CNT_W-1:0]  repeat_ticks;
        logic [IDLE_W-1:0] second_ticks;
    } tarc_cfg_t;

    typedef struct packed {
        logic advance_second;
        logic inc_dec;
        logic clear_touch;
        logic clock_enabled;
    } tarc_result_t;

endpackage

FILE: rtl/core/tarc_cfg.sv
// Configuration register file.
module tarc_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tarc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tarc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tarc_pkg::tarc_cfg_t               cfg
);
    import tarc_pkg::*;

    tarc_cfg_t cfg_reg;
    tarc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SETTLE:     cfg_next.settle_ticks     = cfg_data[CNT_W-1:0];
                REG_AUTO_DELAY: cfg_next.auto_delay_ticks = cfg_data[CNT_W-1:0];
                REG_REPEAT:     cfg_next.repeat_ticks     = cfg_data[CNT_W-1:0];
                REG_SECOND:     cfg_next.second_ticks     = cfg_data[IDLE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks     <= SETTLE_RST;
            cfg_reg.auto_delay_ticks <= AUTO_DELAY_RST;
            cfg_reg.repeat_ticks     <= REPEAT_RST;
            cfg_reg.second_ticks     <= SECOND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/tarc_fsm.sv
// Touch controller state machine with its timers; one tick per accepted request.
module tarc_fsm
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    tick,
    input  logic                    touched,
    input  tarc_pkg::tarc_cfg_t     cfg,
    output tarc_pkg::tarc_result_t  result
);
    import tarc_pkg::*;

    typedef enum logic [7:0] {
        ST_INIT        = 8'b0000_0001,
        ST_NEVER       = 8'b0000_0010,
        ST_WAIT        = 8'b0000_0100,
        ST_SETTLE      = 8'b0000_1000,
        ST_HOLD        = 8'b0001_0000,
        ST_REPEAT      = 8'b0010_0000,
        ST_REPEAT_DONE = 8'b0100_0000,
        ST_ADD_SECOND  = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  settle_reg, settle_next;
    logic [CNT_W-1:0]  hold_reg, hold_next;
    logic [CNT_W-1:0]  repeat_reg, repeat_next;
    logic [IDLE_W-1:0] idle_reg, idle_next;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    always_comb
    begin
        state_next            = state_reg;
        settle_next           = settle_reg;
        hold_next             = hold_reg;
        repeat_next           = repeat_reg;
        idle_next             = idle_reg;
        result.advance_second = 1'b0;
        result.inc_dec        = 1'b0;
        result.clear_touch    = 1'b0;

        // action of the current state, then the transition on updated counts
        case (state_reg)
            ST_INIT:
            begin
                state_next = ST_NEVER;
            end
            ST_NEVER:
            begin
                if (touched)
                begin
                    state_next         = ST_WAIT;
                    result.clear_touch = 1'b1;
                end
            end
            ST_WAIT:
            begin
                settle_next = '0;
                hold_next   = '0;
                repeat_next = '0;
                if (touched)
                begin
                    state_next         = ST_SETTLE;
                    result.clear_touch = 1'b1;
                end
                else if (idle_reg >= cfg.second_ticks)
                begin
                    state_next         = ST_ADD_SECOND;
                    result.clear_touch = 1'b1;
                end
                else if (idle_reg != IDLE_MAX)
                begin
                    idle_next = idle_reg + 1'b1;
                end
            end
            ST_SETTLE:
            begin
                settle_next = sat_inc(settle_reg);
                idle_next   = '0;
                if (settle_next >= cfg.settle_ticks)
                begin
                    if (touched)
                        state_next = ST_HOLD;
                    else
                    begin
                        state_next     = ST_WAIT;
                        result.inc_dec = 1'b1;
                    end
                end
            end
            ST_HOLD:
            begin
                hold_next = sat_inc(hold_reg);
                idle_next = '0;
                if (!touched)
                begin
                    state_next     = ST_WAIT;
                    result.inc_dec = 1'b1;
                end
                else if (hold_next >= cfg.auto_delay_ticks)
                begin
                    state_next     = ST_REPEAT;
                    result.inc_dec = 1'b1;
                end
            end
            ST_REPEAT:
            begin
                repeat_next = sat_inc(repeat_reg);
                idle_next   = '0;
                if (!touched)
                    state_next = ST_WAIT;
                else if (repeat_next >= cfg.repeat_ticks)
                    state_next = ST_REPEAT_DONE;
            end
            ST_REPEAT_DONE:
            begin
                repeat_next = '0;
                idle_next   = '0;
                if (!touched)
                    state_next = ST_WAIT;
                else
                begin
                    state_next     = ST_REPEAT;
                    result.inc_dec = 1'b1;
                end
            end
            ST_ADD_SECOND:
            begin
                result.advance_second = 1'b1;
                idle_next             = '0;
                state_next            = touched ? ST_SETTLE : ST_WAIT;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        result.clock_enabled = (state_next != ST_INIT) && (state_next != ST_NEVER);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            settle_reg <= '0;
            hold_reg   <= '0;
            repeat_reg <= '0;
            idle_reg   <= '0;
        end
        else if (tick)
        begin
            state_reg  <= state_next;
            settle_reg <= settle_next;
            hold_reg   <= hold_next;
            repeat_reg <= repeat_next;
            idle_reg   <= idle_next;
        end
    end

endmodule

FILE: rtl/core/touch_auto_repeat_clock_controller_unit.sv
// Touch auto-repeat clock controller: top level with the result register.
//
// One touch sample per request; each accepted request yields exactly one result
// request in the next cycle. A new sample is taken every cycle as long as the
// result register is empty or its result is being taken in that same cycle, so
// the sustained rate is one sample per clock. The state machine and its timers
// advance only on accepted samples. Configuration writes are always ready and
// should be made while no result is pending.
module touch_auto_repeat_clock_controller_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              touch_valid,
    output logic                              touch_stall,
    input  logic                              touched,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              advance_second,
    output logic                              inc_dec,
    output logic                              clear_touch,
    output logic                              clock_enabled,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tarc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tarc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tarc_pkg::*;

    tarc_cfg_t    cfg;
    tarc_result_t step_result;
    tarc_result_t result_reg;
    logic         valid_reg, valid_next;
    logic         accept;

    assign touch_stall = valid_reg && result_stall;
    assign accept      = touch_valid && !touch_stall;
    assign valid_next  = accept || (valid_reg && result_stall);

    tarc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tarc_fsm u_fsm
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (accept),
        .touched (touched),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= step_result;
    end

    assign result_valid   = valid_reg;
    assign advance_second = result_reg.advance_second;
    assign inc_dec        = result_reg.inc_dec;
    assign clear_touch    = result_reg.clear_touch;
    assign clock_enabled  = result_reg.clock_enabled;

endmodule

FILE: sim/tarc_checker.sv
// Result checker for the touch auto-repeat clock controller: tracks config, predicts, compares.
module tarc_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            touch_valid,
    input  logic                            touch_stall,
    input  logic                            touched,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  logic                            advance_second,
    input  logic                            inc_dec,
    input  logic                            clear_touch,
    input  logic                            clock_enabled,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [tarc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tarc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tarc_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_NEVER,
        S_WAIT,
        S_SETTLE,
        S_HOLD,
        S_REPEAT,
        S_REPEAT_DONE,
        S_ADD_SECOND
    } ctl_state_e;

    // bit position in tarc_result_t -> field name
    string field_name [4] = '{"clock_enabled", "clear_touch", "inc_dec", "advance_second"};

    tarc_cfg_t        regs;
    ctl_state_e       ctl_st;
    logic [CNT_W-1:0] settle_cnt;
    logic [CNT_W-1:0] hold_cnt;
    logic [CNT_W-1:0] rpt_cnt;
    logic [IDLE_W-1:0] idle_cnt;
    tarc_result_t     expected_pulses [$];

    // One tick of the controller: state action first, then the transition.
    function automatic tarc_result_t tick_controller(input logic t);
        tarc_result_t r;
        ctl_state_e   nxt;
        r   = '0;
        nxt = ctl_st;
        case (ctl_st)
            S_WAIT:
            begin
                settle_cnt = '0;
                hold_cnt   = '0;
                rpt_cnt    = '0;
            end
            S_SETTLE:
            begin
                if (settle_cnt != CNT_MAX) settle_cnt = settle_cnt + 1'b1;
                idle_cnt = '0;
            end
            S_HOLD:
            begin
                if (hold_cnt != CNT_MAX) hold_cnt = hold_cnt + 1'b1;
                idle_cnt = '0;
            end
            S_REPEAT:
            begin
                if (rpt_cnt != CNT_MAX) rpt_cnt = rpt_cnt + 1'b1;
                idle_cnt = '0;
            end
            S_REPEAT_DONE:
            begin
                rpt_cnt  = '0;
                idle_cnt = '0;
            end
            S_ADD_SECOND:
            begin
                r.advance_second = 1'b1;
                idle_cnt         = '0;
            end
            default:
            begin
            end
        endcase

        case (ctl_st)
            S_INIT:
            begin
                nxt = S_NEVER;
            end
            S_NEVER:
            begin
                if (t)
                begin
                    nxt           = S_WAIT;
                    r.clear_touch = 1'b1;
                end
            end
            S_WAIT:
            begin
                if (t)
                begin
                    nxt           = S_SETTLE;
                    r.clear_touch = 1'b1;
                end
                else if (idle_cnt >= regs.second_ticks)
                begin
                    nxt           = S_ADD_SECOND;
                    r.clear_touch = 1'b1;
                end
                else if (idle_cnt != IDLE_MAX)
                begin
                    idle_cnt = idle_cnt + 1'b1;
                end
            end
            S_SETTLE:
            begin
                if (settle_cnt >= regs.settle_ticks)
                begin
                    if (t)
                    begin
                        nxt = S_HOLD;
                    end
                    else
                    begin
                        nxt       = S_WAIT;
                        r.inc_dec = 1'b1;
                    end
                end
            end
            S_HOLD:
            begin
                if (!t)
                begin
                    nxt       = S_WAIT;
                    r.inc_dec = 1'b1;
                end
                else if (hold_cnt >= regs.auto_delay_ticks)
                begin
                    nxt       = S_REPEAT;
                    r.inc_dec = 1'b1;
                end
            end
            S_REPEAT:
            begin
                // release while repeating gives no pulse
                if (!t) nxt = S_WAIT;
                else if (rpt_cnt >= regs.repeat_ticks) nxt = S_REPEAT_DONE;
            end
            S_REPEAT_DONE:
            begin
                if (!t)
                begin
                    nxt = S_WAIT;
                end
                else
                begin
                    nxt       = S_REPEAT;
                    r.inc_dec = 1'b1;
                end
            end
            default:
            begin
                nxt = t ? S_SETTLE : S_WAIT;
            end
        endcase

        ctl_st          = nxt;
        r.clock_enabled = (nxt != S_INIT) && (nxt != S_NEVER);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tarc_result_t got;
        tarc_result_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            expected_pulses.delete();
            regs       = '{SETTLE_RST, AUTO_DELAY_RST, REPEAT_RST, SECOND_RST};
            ctl_st     = S_INIT;
            settle_cnt = '0;
            hold_cnt   = '0;
            rpt_cnt    = '0;
            idle_cnt   = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SETTLE:     regs.settle_ticks     = cfg_data[CNT_W-1:0];
                    REG_AUTO_DELAY: regs.auto_delay_ticks = cfg_data[CNT_W-1:0];
                    REG_REPEAT:     regs.repeat_ticks     = cfg_data[CNT_W-1:0];
                    REG_SECOND:     regs.second_ticks     = cfg_data[IDLE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // results are checked before this edge's request is predicted
            if (result_valid && !result_stall)
            begin
                got = '{advance_second, inc_dec, clear_touch, clock_enabled};
                if (expected_pulses.size() == 0)
                begin
                    $error("result with no request outstanding: %b", got);
                    fail_count++;
                end
                else
                begin
                    want = expected_pulses.pop_front();
                    for (int i = 0; i < 4; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            $error("%s: expected %0b, got %0b", field_name[i], want[i], got[i]);
                            fail_count++;
                        end
                    end
                end
            end

            if (touch_valid && !touch_stall)
                expected_pulses.push_back(tick_controller(touched));
        end
        pending = expected_pulses.size();
    end

endmodule

FILE: sim/tb_touch_auto_repeat_clock_controller_unit.sv
// Testbench top for the touch auto-repeat clock controller: clock, reset, stimulus, verdict.
module tb_touch_auto_repeat_clock_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import tarc_pkg::*;

    localparam int LONG_HOLD = 300;
    // touch sequence for the opening check, sent MSB first
    localparam logic [26:0] DIRECTED_TOUCHES = 27'b101_00000_10_110_111111110_00001;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  touch_valid  = 1'b0;
    logic                  touched      = 1'b0;
    logic                  result_stall = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  touch_stall;
    logic                  result_valid;
    logic                  advance_second;
    logic                  inc_dec;
    logic                  clear_touch;
    logic                  clock_enabled;
    logic                  cfg_ready;

    int mismatch_count;
    int results_outstanding;
    int items_sent    = 0;
    bit idling        = 1'b0;
    bit long_hold_req = 1'b0;
    int eff_settle;
    int eff_auto;
    int eff_rpt;
    int eff_sec;

    touch_auto_repeat_clock_controller_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .touch_valid    (touch_valid),
        .touch_stall    (touch_stall),
        .touched        (touched),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .advance_second (advance_second),
        .inc_dec        (inc_dec),
        .clear_touch    (clear_touch),
        .clock_enabled  (clock_enabled),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    tarc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .touch_valid    (touch_valid),
        .touch_stall    (touch_stall),
        .touched        (touched),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .advance_second (advance_second),
        .inc_dec        (inc_dec),
        .clear_touch    (clear_touch),
        .clock_enabled  (clock_enabled),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (mismatch_count),
        .pending        (results_outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin : result_sink
        int burst;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
                result_stall <= 1'b0;
            end
            else if (burst > 0)
            begin
                burst--;
                result_stall <= 1'b1;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(0, 15);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with valid possibly still high.
    task automatic send_touch(input logic t);
        touch_valid <= 1'b1;
        touched     <= t;
        do @(posedge clk); while (touch_stall);
        items_sent++;
        @(negedge clk);
        if (idling && $urandom_range(0, 5) == 0)
        begin
            touch_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        touch_valid <= 1'b0;
        while (results_outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] s, input logic [CFG_DATA_W-1:0] a,
                                input logic [CFG_DATA_W-1:0] r, input logic [CFG_DATA_W-1:0] sec);
        wait_drained();
        repeat (3) @(negedge clk);
        write_reg(REG_SETTLE, s);
        write_reg(REG_AUTO_DELAY, a);
        write_reg(REG_REPEAT, r);
        write_reg(REG_SECOND, sec);
        eff_settle = int'(s[CNT_W-1:0]);
        eff_auto   = int'(a[CNT_W-1:0]);
        eff_rpt    = int'(r[CNT_W-1:0]);
        eff_sec    = int'(sec);
    endtask

    task automatic program_small();
        program_regs(10'($urandom_range(1, 4)), 10'($urandom_range(1, 6)),
                     10'($urandom_range(1, 4)), 10'($urandom_range(0, 24)));
    endtask

    // Mostly press/release gestures sized to the current timers, some noise.
    task automatic run_phase(input int budget);
        int stop_at;
        int press_len;
        int idle_len;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 8)) send_touch(1'($urandom_range(0, 1)));
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       press_len = $urandom_range(1, eff_settle + 2);
                    1:       press_len = $urandom_range(eff_settle + 1, eff_settle + eff_auto + 3);
                    default: press_len = eff_settle + eff_auto + $urandom_range(1, 4 * (eff_rpt + 2));
                endcase
                repeat (press_len) send_touch(1'b1);
                if ($urandom_range(0, 3) == 0)
                    idle_len = eff_sec + $urandom_range(1, 4);
                else
                    idle_len = $urandom_range(1, eff_sec + 2);
                repeat (idle_len) send_touch(1'b0);
            end
        end
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // opening check: init tick, first touch, second tick, release in settle,
        // release in auto delay, auto-repeat, release in repeat, touch on second tick
        program_regs(10'd1, 10'd2, 10'd1, 10'd3);
        for (int i = 26; i >= 0; i--)
            send_touch(DIRECTED_TOUCHES[i]);

        idling = 1'b1;
        program_small();
        run_phase(100);
        long_hold_req = 1'b1;
        run_phase(100);
        wait_drained();
        run_phase(50);

        // zero limits, upper data bits set on the 8-bit registers
        program_regs(10'h300, 10'h000, 10'h200, 10'h000);
        run_phase(150);

        // largest limits: full settle, auto delay and repeat
        program_regs(10'h3FF, 10'h0FF, 10'h1FF, 10'h3FF);
        repeat (775) send_touch(1'b1);
        repeat (40) send_touch(1'b0);

        idling = 1'b0;
        program_small();
        run_phase(50);
        idling = 1'b1;
        program_small();
        run_phase(50);
        program_small();
        run_phase(50);
        idling = 1'b0;
        program_small();
        run_phase(50);

        wait_drained();
        repeat (4) @(negedge clk);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
